>>> sv/diff_drive_wheel_speed_frame_core_defines.svh
// Assertion macros shared by the checker of the wheel speed frame core.
`ifndef DIFF_DRIVE_WHEEL_SPEED_FRAME_CORE_DEFINES_SVH
`define DIFF_DRIVE_WHEEL_SPEED_FRAME_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDWS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Property that must also hold while reset is asserted.
`define DDWS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

>>> sv/ddws_pkg.sv
// Shared types, constants and character codes of the wheel speed frame core.
package ddws_pkg;

	// Configuration port geometry.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	// Register widths and reset values.
	localparam int unsigned TRACK_W = 14;
	localparam int unsigned SCALE_W = 16;
	localparam logic [TRACK_W-1:0] TRACK_RESET = 14'd983;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

	// Payload widths.
	localparam int unsigned VEL_W  = 16;
	localparam int unsigned BYTE_W = 8;

	// Saturation limit of a wheel speed magnitude.
	localparam logic [9:0] SPEED_CAP = 10'd999;

	// Default depth of the queue between front and back.
	localparam int unsigned FIFO_DEPTH_DEF = 4;

	// ASCII characters of the frame.
	localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_TERM  = 8'h3F;

	// Register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WHEEL_TRACK,
		REG_SPEED_SCALE
	} cfg_reg_t;

	// One configuration write.
	typedef struct packed {
		logic                  we;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} ddws_cfg_t;

	// One wheel speed, already split into sign and decimal digits.
	typedef struct packed {
		logic       neg;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} ddws_wheel_t;

	// Both wheels of one command.
	typedef struct packed {
		ddws_wheel_t left;
		ddws_wheel_t right;
	} ddws_speeds_t;

	// Write side of the queue.
	typedef struct packed {
		logic         valid;
		ddws_speeds_t data;
	} ddws_push_t;

	// Read side of the queue.
	typedef struct packed {
		logic         valid;
		ddws_speeds_t data;
	} ddws_head_t;

	// Digit and remainder of one decimal place.
	typedef struct packed {
		logic [3:0] digit;
		logic [9:0] rem;
	} ddws_digit_t;

	// Sign and saturated magnitude of one wheel.
	typedef struct packed {
		logic       neg;
		logic [9:0] mag;
	} ddws_mag_t;

endpackage

>>> sv/ddws_if.sv
// Handshake channel interfaces for velocity commands and frame bytes.
interface ddws_cmd_if;
	logic                             valid;
	logic                             ready;
	logic signed [ddws_pkg::VEL_W-1:0] linear_velocity;
	logic signed [ddws_pkg::VEL_W-1:0] angular_velocity;

	modport source (output valid, output linear_velocity, output angular_velocity, input ready);
	modport sink (input valid, input linear_velocity, input angular_velocity, output ready);
endinterface

interface ddws_frame_if;
	logic                        valid;
	logic                        ready;
	logic [ddws_pkg::BYTE_W-1:0] frame_byte;
	logic                        last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

>>> sv/diff_drive_wheel_speed_frame_core.sv
// Top level of the differential drive wheel speed frame core.
// A command passes the front pipeline, the queue and the output byte register before its first byte is shown.
// One frame byte per cycle while frame.ready is high; the byte serializer sends nine bytes per command.
// Commands are taken every cycle until FIFO_DEPTH frames are in flight or queued.
// Reset is asynchronous: pipeline, queue and output are emptied, wheel_track becomes 983
// and speed_scale 1000.
module diff_drive_wheel_speed_frame_core #(
	parameter int unsigned FIFO_DEPTH = ddws_pkg::FIFO_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ddws_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ddws_pkg::CFG_DATA_W-1:0]   cfg_data,
	ddws_cmd_if.sink                          cmd,
	ddws_frame_if.source                      frame
);

	ddws_pkg::ddws_cfg_t  cfg;
	ddws_pkg::ddws_push_t push;
	ddws_pkg::ddws_head_t head;
	logic                 pop;

	// Configuration write bundle.
	assign cfg.we    = cfg_we;
	assign cfg.index = ddws_pkg::cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_data;

	ddws_front #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.cmd   (cmd),
		.pop   (pop),
		.push  (push)
	);

	ddws_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head)
	);

	ddws_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.frame (frame)
	);

endmodule

>>> sv/ddws_front.sv
// Front end: configuration registers, command intake and the speed/digit pipeline.
module ddws_front #(
	parameter int unsigned FIFO_DEPTH = ddws_pkg::FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddws_pkg::ddws_cfg_t  cfg,
	ddws_cmd_if.sink             cmd,
	input  logic                 pop,
	output ddws_pkg::ddws_push_t push
);

	localparam int unsigned CREDIT_W = $clog2(FIFO_DEPTH + 1);

	// Splits off one decimal place by parallel compares against its multiples.
	function automatic ddws_pkg::ddws_digit_t split_digit(input logic [9:0] val,
			input logic [9:0] unit);
		ddws_pkg::ddws_digit_t r;
		r.digit = 4'd0;
		r.rem   = val;
		for (int k = 1; k <= 9; k++) begin
			if (val >= 10'(k) * unit) begin
				r.digit = 4'(k);
				r.rem   = val - 10'(k) * unit;
			end
		end
		return r;
	endfunction

	// Magnitude truncated toward zero, saturated, with the sign of the truncated value.
	function automatic ddws_pkg::ddws_mag_t wheel_mag(input logic signed [47:0] prod);
		ddws_pkg::ddws_mag_t r;
		logic [47:0] abs_v;
		logic [22:0] m;
		abs_v = prod[47] ? 48'(-prod) : 48'(prod);
		m     = abs_v[47:25];
		r.neg = prod[47] && (m != 23'd0);
		r.mag = (m > 23'(ddws_pkg::SPEED_CAP)) ? ddws_pkg::SPEED_CAP : m[9:0];
		return r;
	endfunction

	logic [ddws_pkg::TRACK_W-1:0] track_q;
	logic [ddws_pkg::SCALE_W-1:0] scale_q;
	logic [CREDIT_W-1:0]          credit_q;
	logic                         accept;

	// Stage valids.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// Stage payloads.
	logic signed [15:0]   v_s1;
	logic signed [30:0]   wt_s1;
	logic signed [30:0]   num_l_s2, num_r_s2;
	logic signed [47:0]   prod_l_s3, prod_r_s3;
	ddws_pkg::ddws_mag_t  mag_l_s4, mag_r_s4;
	ddws_pkg::ddws_mag_t  mag_l_next, mag_r_next;
	logic                 neg_l_s5, neg_r_s5;
	ddws_pkg::ddws_digit_t hund_l_s5, hund_r_s5;
	ddws_pkg::ddws_digit_t hund_l_next, hund_r_next;
	ddws_pkg::ddws_digit_t tens_l, tens_r;
	logic signed [30:0]   v8k;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= ddws_pkg::TRACK_RESET;
			scale_q <= ddws_pkg::SCALE_RESET;
		end else if (cfg.we) begin
			unique case (cfg.index)
				ddws_pkg::REG_WHEEL_TRACK: track_q <= cfg.data[ddws_pkg::TRACK_W-1:0];
				ddws_pkg::REG_SPEED_SCALE: scale_q <= cfg.data[ddws_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Credits count commands accepted whose frame has not left the queue yet.
	assign cmd.ready = credit_q < CREDIT_W'(FIFO_DEPTH);
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !pop) begin
			credit_q <= credit_q + CREDIT_W'(1);
		end else if (pop && !accept) begin
			credit_q <= credit_q - CREDIT_W'(1);
		end
	end

	// Valid bits travel down the pipeline without stalling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Combinational parts of the stages.
	assign v8k         = {{2{v_s1[15]}}, v_s1, 13'd0};
	assign mag_l_next  = wheel_mag(prod_l_s3);
	assign mag_r_next  = wheel_mag(prod_r_s3);
	assign hund_l_next = split_digit(mag_l_s4.mag, 10'd100);
	assign hund_r_next = split_digit(mag_r_s4.mag, 10'd100);
	assign tens_l      = split_digit(hund_l_s5.rem, 10'd10);
	assign tens_r      = split_digit(hund_r_s5.rem, 10'd10);

	// Stage 1 forms w * track, stage 2 the two numerators, stage 3 the scaling.
	// Stage 4 truncates and saturates, stage 5 takes off the hundreds digit.
	always_ff @(posedge clk) begin
		v_s1      <= cmd.linear_velocity;
		wt_s1     <= 31'(cmd.angular_velocity * $signed({1'b0, track_q}));
		num_l_s2  <= v8k - wt_s1;
		num_r_s2  <= v8k + wt_s1;
		prod_l_s3 <= 48'(num_l_s2 * $signed({1'b0, scale_q}));
		prod_r_s3 <= 48'(num_r_s2 * $signed({1'b0, scale_q}));
		mag_l_s4  <= mag_l_next;
		mag_r_s4  <= mag_r_next;
		neg_l_s5  <= mag_l_s4.neg;
		neg_r_s5  <= mag_r_s4.neg;
		hund_l_s5 <= hund_l_next;
		hund_r_s5 <= hund_r_next;
	end

	// Tens and ones are split off on the way into the queue.
	assign push.valid           = valid_s5;
	assign push.data.left.neg   = neg_l_s5;
	assign push.data.left.hund  = hund_l_s5.digit;
	assign push.data.left.tens  = tens_l.digit;
	assign push.data.left.ones  = tens_l.rem[3:0];
	assign push.data.right.neg  = neg_r_s5;
	assign push.data.right.hund = hund_r_s5.digit;
	assign push.data.right.tens = tens_r.digit;
	assign push.data.right.ones = tens_r.rem[3:0];

endmodule

>>> sv/ddws_fifo.sv
// Small register queue of decoded wheel speeds between front and back.
module ddws_fifo #(
	parameter int unsigned DEPTH = ddws_pkg::FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddws_pkg::ddws_push_t push,
	input  logic                 pop,
	output ddws_pkg::ddws_head_t head
);

	localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	ddws_pkg::ddws_speeds_t entries_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [COUNT_W-1:0]     count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.data;
		end
	end

	// Pointers and fill count; the front never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end

	assign head.valid = count_q != '0;
	assign head.data  = entries_q[rd_ptr_q];

endmodule

>>> sv/ddws_back.sv
// Back end: serializes one queued entry into nine ASCII bytes.
module ddws_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddws_pkg::ddws_head_t head,
	output logic                 pop,
	ddws_frame_if.source         frame
);

	// Byte positions within the frame.
	localparam logic [3:0] POS_L_SIGN = 4'd0;
	localparam logic [3:0] POS_L_HUND = 4'd1;
	localparam logic [3:0] POS_L_TENS = 4'd2;
	localparam logic [3:0] POS_L_ONES = 4'd3;
	localparam logic [3:0] POS_R_SIGN = 4'd4;
	localparam logic [3:0] POS_R_HUND = 4'd5;
	localparam logic [3:0] POS_R_TENS = 4'd6;
	localparam logic [3:0] POS_R_ONES = 4'd7;
	localparam logic [3:0] POS_TERM   = 4'd8;

	logic [3:0]                  pos_q;
	logic                        valid_q;
	logic [ddws_pkg::BYTE_W-1:0] byte_q;
	logic                        last_q;
	logic                        load;
	logic [ddws_pkg::BYTE_W-1:0] byte_next;

	// A new beat is loaded whenever the output register is empty or being taken.
	assign load = head.valid && (!valid_q || frame.ready);
	assign pop  = load && (pos_q == POS_TERM);

	// Character for the current position.
	always_comb begin
		unique case (pos_q)
			POS_L_SIGN: byte_next = head.data.left.neg ? ddws_pkg::CHAR_MINUS : ddws_pkg::CHAR_PLUS;
			POS_L_HUND: byte_next = ddws_pkg::CHAR_ZERO + {4'd0, head.data.left.hund};
			POS_L_TENS: byte_next = ddws_pkg::CHAR_ZERO + {4'd0, head.data.left.tens};
			POS_L_ONES: byte_next = ddws_pkg::CHAR_ZERO + {4'd0, head.data.left.ones};
			POS_R_SIGN: byte_next = head.data.right.neg ? ddws_pkg::CHAR_MINUS : ddws_pkg::CHAR_PLUS;
			POS_R_HUND: byte_next = ddws_pkg::CHAR_ZERO + {4'd0, head.data.right.hund};
			POS_R_TENS: byte_next = ddws_pkg::CHAR_ZERO + {4'd0, head.data.right.tens};
			POS_R_ONES: byte_next = ddws_pkg::CHAR_ZERO + {4'd0, head.data.right.ones};
			default:    byte_next = ddws_pkg::CHAR_TERM;
		endcase
	end

	// Position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_L_SIGN;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q   <= (pos_q == POS_TERM) ? POS_L_SIGN : pos_q + 4'd1;
				valid_q <= 1'b1;
			end else if (frame.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_next;
			last_q <= pos_q == POS_TERM;
		end
	end

	assign frame.valid      = valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.last_byte  = last_q;

endmodule

>>> sv/ddws_checker.sv
// Port-level checker of the wheel speed frame core and its bind.
`include "diff_drive_wheel_speed_frame_core_defines.svh"

module ddws_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        frame_valid,
	input logic                        frame_ready,
	input logic [ddws_pkg::BYTE_W-1:0] frame_byte,
	input logic                        last_byte
);

	// A stalled beat keeps its payload.
	`DDWS_ASSERT_NEXT(a_hold_stalled, frame_valid && !frame_ready, frame_valid && $stable(frame_byte) && $stable(last_byte), "stalled beat changed")

	// The terminator appears exactly on the last beat.
	`DDWS_ASSERT_IMPL(a_last_is_term, frame_valid, last_byte == (frame_byte == ddws_pkg::CHAR_TERM), "last marker and terminator disagree")

	// A frame streams without gaps once started.
	`DDWS_ASSERT_NEXT(a_no_gap, frame_valid && frame_ready && !last_byte, frame_valid, "gap inside a frame")

	// Every byte is a sign, a digit or the terminator.
	`DDWS_ASSERT_IMPL(a_charset, frame_valid, frame_byte == ddws_pkg::CHAR_PLUS || frame_byte == ddws_pkg::CHAR_MINUS || frame_byte == ddws_pkg::CHAR_TERM || (frame_byte >= ddws_pkg::CHAR_ZERO && frame_byte <= ddws_pkg::CHAR_NINE), "byte outside frame alphabet")

	// No beat is offered while reset is held.
	`DDWS_ASSERT_ALWAYS(a_reset_quiet, arst_n || !frame_valid, "output valid during reset")

endmodule

bind diff_drive_wheel_speed_frame_core ddws_checker u_ddws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.frame_valid(frame.valid),
	.frame_ready(frame.ready),
	.frame_byte (frame.frame_byte),
	.last_byte  (frame.last_byte)
);
